FILE: rtl/core/blpd_pkg.sv
// Shared types and constants for the bright line pixel detector.
// Configuration register map, reset values and field widths.
// No dependencies.
package blpd_pkg;

	localparam int LUMA_W      = 8;
	localparam int COORD_W     = 11;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LUMA_TH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIFF_TH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FG_VALUE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_VALUE = 3'd5;

	// reset values
	localparam logic [7:0]  LUMA_TH_RST  = 8'd80;
	localparam logic [7:0]  DIFF_TH_RST  = 8'd20;
	localparam logic [3:0]  OFFSET_RST   = 4'd4;
	localparam logic [11:0] WIDTH_RST    = 12'd640;
	localparam logic [7:0]  FG_VALUE_RST = 8'd255;
	localparam logic [7:0]  BG_VALUE_RST = 8'd0;

	typedef struct packed {
		logic [7:0]  luma_th;
		logic [7:0]  diff_th;
		logic [3:0]  probe_offset;
		logic [11:0] image_width;
		logic [7:0]  fg_value;
		logic [7:0]  bg_value;
	} cfg_regs_t;

endpackage

FILE: rtl/core/bright_line_pixel_detector.sv
// Top level of the bright line pixel detector (cross stencil).
// Depends on blpd_pkg, blpd_cfg, blpd_front, blpd_ram and blpd_stencil.
//
// Usage:
//   Input channel (in_valid / in_stall): luma pixels in raster order, with
//   frame_start on a frame's first pixel. Unstalled, one transfer per clock.
//   Output channel (out_valid / out_stall): one result for each pixel (x, y)
//   with x and y at least 2t, describing centre (x-t, y-t). Other pixels
//   give no result.
//   Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
// Pipeline: the input stage with the store read, then the result register.
// Throughput: one pixel per cycle while not stalled, set by the single-pass
//   stencil logic and the two read ports of the line store, which serve the
//   centre row and the top row while the current pixel is written.
// Stall: when a result waits with out_stall high the whole pipe, including
//   the line store read registers, holds and in_stall is raised.
// Reset: position counters clear to the origin and registers take their
//   reset values. The line store is not cleared; entries are only read after
//   they have been written in the current frame.
module bright_line_pixel_detector #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_OFFSET = 8,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [blpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [blpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [blpd_pkg::LUMA_W-1:0]      luma,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [blpd_pkg::COORD_W-1:0]     center_x,
	output logic [blpd_pkg::COORD_W-1:0]     center_y,
	output logic [blpd_pkg::LUMA_W-1:0]      pixel_value,
	output logic                             is_line
);
	import blpd_pkg::*;

	localparam int STORE_LINES = 2*MAX_OFFSET + 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int OFF_W  = $clog2(MAX_OFFSET+1);
	localparam int WW     = $clog2(MAX_WIDTH+1);
	localparam int ADDR_W = $clog2(STORE_LINES) + COL_W;
	localparam int DEPTH  = STORE_LINES * (2**COL_W);

	cfg_regs_t          regs;
	logic [OFF_W-1:0]   t_eff;
	logic [WW-1:0]      w_eff;

	logic               adv, accept;
	logic               produce;
	logic [COL_W-1:0]   cx;
	logic [ROW_W-1:0]   cy;
	logic [ADDR_W-1:0]  waddr, centre_addr, top_addr;
	logic [LUMA_W-1:0]  rd_centre, rd_top;
	logic               line_hit;

	// stage 1: store read data lands alongside these
	logic               valid_s1, produce_s1;
	logic [LUMA_W-1:0]  luma_s1;
	logic [COL_W-1:0]   cx_s1;
	logic [ROW_W-1:0]   cy_s1;

	// result register
	logic               out_valid_q, is_line_q;
	logic [COORD_W-1:0] center_x_q, center_y_q;
	logic [LUMA_W-1:0]  pixel_value_q;

	// the pipe moves unless a result is waiting on a stalled receiver
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	blpd_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_OFFSET (MAX_OFFSET)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regs      (regs),
		.t_eff     (t_eff),
		.w_eff     (w_eff)
	);

	blpd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_OFFSET (MAX_OFFSET),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (frame_start),
		.t_eff       (t_eff),
		.w_eff       (w_eff),
		.produce     (produce),
		.cx          (cx),
		.cy          (cy),
		.waddr       (waddr),
		.centre_addr (centre_addr),
		.top_addr    (top_addr)
	);

	// line store: write the new pixel, read centre row (current column) and
	// top row (centre column); the three slots never coincide
	blpd_ram #(
		.WIDTH (LUMA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (accept),
		.waddr   (waddr),
		.wdata   (luma),
		.re      (adv),
		.raddr_a (centre_addr),
		.raddr_b (top_addr),
		.rdata_a (rd_centre),
		.rdata_b (rd_top)
	);

	blpd_stencil #(
		.MAX_OFFSET (MAX_OFFSET)
	) u_stencil (
		.clk       (clk),
		.shift     (valid_s1 && adv),
		.luma_s1   (luma_s1),
		.rd_centre (rd_centre),
		.rd_top    (rd_top),
		.t_eff     (t_eff),
		.regs      (regs),
		.is_line   (line_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1 && produce_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			produce_s1    <= produce;
			luma_s1       <= luma;
			cx_s1         <= cx;
			cy_s1         <= cy;
			center_x_q    <= COORD_W'(cx_s1);
			center_y_q    <= COORD_W'(cy_s1);
			is_line_q     <= line_hit;
			pixel_value_q <= line_hit ? regs.fg_value : regs.bg_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign center_x    = center_x_q;
	assign center_y    = center_y_q;
	assign pixel_value = pixel_value_q;
	assign is_line     = is_line_q;

endmodule

FILE: rtl/core/blpd_ram.sv
// Generic simple RAM: one write port, two read ports, registered reads.
// No dependencies.
module blpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: rtl/core/blpd_cfg.sv
// Configuration register file with clamped probe offset and line width.
// Depends on blpd_pkg.
module blpd_cfg #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_OFFSET = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [blpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [blpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output blpd_pkg::cfg_regs_t                 regs,
	output logic [$clog2(MAX_OFFSET+1)-1:0]     t_eff,
	output logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff
);
	import blpd_pkg::*;

	localparam int OFF_W = $clog2(MAX_OFFSET+1);
	localparam int WW    = $clog2(MAX_WIDTH+1);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.luma_th      <= LUMA_TH_RST;
			regs_q.diff_th      <= DIFF_TH_RST;
			regs_q.probe_offset <= OFFSET_RST;
			regs_q.image_width  <= WIDTH_RST;
			regs_q.fg_value     <= FG_VALUE_RST;
			regs_q.bg_value     <= BG_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LUMA_TH:  regs_q.luma_th      <= cfg_wdata[7:0];
				REG_DIFF_TH:  regs_q.diff_th      <= cfg_wdata[7:0];
				REG_OFFSET:   regs_q.probe_offset <= cfg_wdata[3:0];
				REG_WIDTH:    regs_q.image_width  <= cfg_wdata[11:0];
				REG_FG_VALUE: regs_q.fg_value     <= cfg_wdata[7:0];
				REG_BG_VALUE: regs_q.bg_value     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

	// zero acts as one, oversize values clamp to the maximum
	always_comb begin
		if (regs_q.probe_offset == 4'd0) begin
			t_eff = OFF_W'(1);
		end else if (32'(regs_q.probe_offset) > MAX_OFFSET) begin
			t_eff = OFF_W'(MAX_OFFSET);
		end else begin
			t_eff = OFF_W'(regs_q.probe_offset);
		end

		if (regs_q.image_width == 12'd0) begin
			w_eff = WW'(1);
		end else if (32'(regs_q.image_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(regs_q.image_width);
		end
	end

endmodule

FILE: rtl/core/blpd_front.sv
// Raster position tracking and line store addressing.
// No package dependencies; widths follow the module parameters.
module blpd_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_OFFSET = 8,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                accept,
	input  logic                                                frame_start,
	input  logic [$clog2(MAX_OFFSET+1)-1:0]                     t_eff,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]                      w_eff,
	output logic                                                produce,
	output logic [$clog2(MAX_WIDTH)-1:0]                        cx,
	output logic [$clog2(MAX_HEIGHT)-1:0]                       cy,
	output logic [$clog2(2*MAX_OFFSET+1)+$clog2(MAX_WIDTH)-1:0] waddr,
	output logic [$clog2(2*MAX_OFFSET+1)+$clog2(MAX_WIDTH)-1:0] centre_addr,
	output logic [$clog2(2*MAX_OFFSET+1)+$clog2(MAX_WIDTH)-1:0] top_addr
);

	localparam int STORE_LINES = 2*MAX_OFFSET + 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int OFF_W  = $clog2(MAX_OFFSET+1);
	localparam int WW     = $clog2(MAX_WIDTH+1);
	localparam int SLOT_W = $clog2(STORE_LINES);
	localparam int CMP_W  = COL_W + ROW_W + OFF_W + 1;

	logic [COL_W-1:0]  col_q, col;
	logic [ROW_W-1:0]  row_q, row;
	logic [SLOT_W-1:0] slot_q, slot;
	logic [OFF_W:0]    two_t;
	logic [SLOT_W:0]   slot_x, t_x, two_t_x, cy_slot_x, top_slot_x;
	logic              line_end;

	// frame_start places this pixel at the origin
	assign col  = frame_start ? '0 : col_q;
	assign row  = frame_start ? '0 : row_q;
	assign slot = frame_start ? '0 : slot_q;

	assign two_t   = {t_eff, 1'b0};
	assign produce = (CMP_W'(col) >= CMP_W'(two_t)) && (CMP_W'(row) >= CMP_W'(two_t));
	assign cx      = col - COL_W'(t_eff);
	assign cy      = row - ROW_W'(t_eff);

	// store slots of the centre row and the top row, modulo the line count
	assign slot_x  = {1'b0, slot};
	assign t_x     = (SLOT_W+1)'(t_eff);
	assign two_t_x = (SLOT_W+1)'(two_t);

	always_comb begin
		if (slot_x >= t_x) begin
			cy_slot_x = slot_x - t_x;
		end else begin
			cy_slot_x = slot_x + (SLOT_W+1)'(STORE_LINES) - t_x;
		end
		if (slot_x >= two_t_x) begin
			top_slot_x = slot_x - two_t_x;
		end else begin
			top_slot_x = slot_x + (SLOT_W+1)'(STORE_LINES) - two_t_x;
		end
	end

	assign waddr       = {slot, col};
	assign centre_addr = {cy_slot_x[SLOT_W-1:0], col};
	assign top_addr    = {top_slot_x[SLOT_W-1:0], cx};

	assign line_end = ((WW+1)'(col) + (WW+1)'(1)) >= (WW+1)'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				// row saturates; the last slot is then reused
				if (32'(row) < MAX_HEIGHT - 1) begin
					row_q  <= row + ROW_W'(1);
					slot_q <= (32'(slot) == STORE_LINES - 1) ? '0 : slot + SLOT_W'(1);
				end else begin
					row_q  <= row;
					slot_q <= slot;
				end
			end else begin
				col_q  <= col + COL_W'(1);
				row_q  <= row;
				slot_q <= slot;
			end
		end
	end

endmodule

FILE: rtl/core/blpd_stencil.sv
// Cross stencil: neighbour shift lines and line pixel decision.
// Depends on blpd_pkg.
module blpd_stencil #(
	parameter int MAX_OFFSET = 8
) (
	input  logic                                clk,
	input  logic                                shift,
	input  logic [blpd_pkg::LUMA_W-1:0]         luma_s1,
	input  logic [blpd_pkg::LUMA_W-1:0]         rd_centre,
	input  logic [blpd_pkg::LUMA_W-1:0]         rd_top,
	input  logic [$clog2(MAX_OFFSET+1)-1:0]     t_eff,
	input  blpd_pkg::cfg_regs_t                 regs,
	output logic                                is_line
);
	import blpd_pkg::*;

	localparam int OFF_W = $clog2(MAX_OFFSET+1);
	localparam int HI_W  = $clog2(2*MAX_OFFSET);
	localparam int VI_W  = (MAX_OFFSET > 1) ? $clog2(MAX_OFFSET) : 1;

	// hline_q: centre-row pixels behind the current one; vline_q: input pixels
	logic [LUMA_W-1:0] hline_q [2*MAX_OFFSET];
	logic [LUMA_W-1:0] vline_q [MAX_OFFSET];

	logic [OFF_W:0]    two_t_m1;
	logic [HI_W-1:0]   idx_v, idx_left;
	logic [VI_W-1:0]   idx_bottom;
	logic [LUMA_W-1:0] v, left, right, top, bottom;
	logic [LUMA_W:0]   left_d, right_d, top_d, bottom_d, v_x;
	logic              horiz, vert;

	always_ff @(posedge clk) begin
		if (shift) begin
			hline_q[0] <= rd_centre;
			for (int i = 1; i < 2*MAX_OFFSET; i++) begin
				hline_q[i] <= hline_q[i-1];
			end
			vline_q[0] <= luma_s1;
			for (int i = 1; i < MAX_OFFSET; i++) begin
				vline_q[i] <= vline_q[i-1];
			end
		end
	end

	assign two_t_m1   = {t_eff, 1'b0} - (OFF_W+1)'(1);
	assign idx_v      = HI_W'(t_eff - OFF_W'(1));
	assign idx_left   = HI_W'(two_t_m1);
	assign idx_bottom = VI_W'(t_eff - OFF_W'(1));

	assign v      = hline_q[idx_v];
	assign left   = hline_q[idx_left];
	assign right  = rd_centre;
	assign top    = rd_top;
	assign bottom = vline_q[idx_bottom];

	// v - n > d  <=>  v > n + d, in nine bits
	assign v_x      = {1'b0, v};
	assign left_d   = {1'b0, left}   + {1'b0, regs.diff_th};
	assign right_d  = {1'b0, right}  + {1'b0, regs.diff_th};
	assign top_d    = {1'b0, top}    + {1'b0, regs.diff_th};
	assign bottom_d = {1'b0, bottom} + {1'b0, regs.diff_th};

	assign horiz   = (v_x > left_d) && (v_x > right_d);
	assign vert    = (v_x > top_d) && (v_x > bottom_d);
	assign is_line = (v >= regs.luma_th) && (horiz || vert);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bright_line_pixel_detector: shaped and random pixel streams,
// a transfer-level predictor of the cross stencil and an in-order result scoreboard.
// Depends on blpd_pkg and the detector RTL.
module testbench;
	import blpd_pkg::*;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_OFFSET   = 8;
	localparam int MAX_HEIGHT   = 2048;
	localparam int STORE_LINES  = 2 * MAX_OFFSET + 1;
	localparam int DRAIN_PAD    = 6;     // margin after the last result
	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD    = 300;   // receiver hold-off, cycles

	typedef enum int {STYLE_NOISE, STYLE_COLUMNS, STYLE_ROWS, STYLE_POINTS} pattern_t;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		logic              frame_start;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LUMA_W-1:0]  value;
		logic               marked;
	} verdict_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_we      = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic [LUMA_W-1:0]      luma        = '0;
	logic                   frame_start = 1'b0;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic [COORD_W-1:0]     center_x;
	logic [COORD_W-1:0]     center_y;
	logic [LUMA_W-1:0]      pixel_value;
	logic                   is_line;

	// predictor state: register copy, line store and raster position
	cfg_regs_t         cfg_copy;
	logic [LUMA_W-1:0] line_mem [STORE_LINES][MAX_WIDTH];
	int                col_pos = 0;
	int                row_pos = 0;

	pixel_t   pixel_queue [$];   // items waiting for the driver
	verdict_t verdicts [$];      // classifications still owed by the block

	int pushed_count   = 0;
	int accepted_count = 0;
	int fail_count     = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;

	// stimulus generator position and shaping
	int       gen_x      = 0;
	int       gen_y      = 0;
	pattern_t gen_style  = STYLE_NOISE;
	int       stripe_gap = 2;

	bright_line_pixel_detector #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_OFFSET(MAX_OFFSET),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.luma(luma),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_x(center_x),
		.center_y(center_y),
		.pixel_value(pixel_value),
		.is_line(is_line)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// out-of-range register values are clamped, not rejected
	function automatic int eff_width(input logic [11:0] w);
		if (w == 0) return 1;
		if (w > MAX_WIDTH) return MAX_WIDTH;
		return int'(w);
	endfunction

	function automatic int eff_offset(input logic [3:0] t);
		if (t == 0) return 1;
		if (t > MAX_OFFSET) return MAX_OFFSET;
		return int'(t);
	endfunction

	// One accepted pixel: store it, classify the centre t back and t up once the
	// stencil fits, then advance the raster position (row saturates).
	function automatic void classify_pixel(input logic [LUMA_W-1:0] lum, input logic fs);
		int       w, t, col, row, cx, cy, d, v, lf, rt, tp, bt;
		bit       hit;
		verdict_t r;
		w = eff_width(cfg_copy.image_width);
		t = eff_offset(cfg_copy.probe_offset);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		col = col_pos;
		row = row_pos;
		line_mem[row % STORE_LINES][col] = lum;
		if (col >= 2 * t && row >= 2 * t) begin
			cx = col - t;
			cy = row - t;
			d  = int'(cfg_copy.diff_th);
			v  = int'(line_mem[cy % STORE_LINES][cx]);
			lf = int'(line_mem[cy % STORE_LINES][col - 2 * t]);
			rt = int'(line_mem[cy % STORE_LINES][col]);
			tp = int'(line_mem[(row - 2 * t) % STORE_LINES][cx]);
			bt = int'(line_mem[row % STORE_LINES][cx]);
			// signed margins: a darker neighbour gives a positive difference
			hit = (v >= int'(cfg_copy.luma_th)) &&
				((v - lf > d && v - rt > d) || (v - tp > d && v - bt > d));
			r.x      = cx[COORD_W-1:0];
			r.y      = cy[COORD_W-1:0];
			r.value  = hit ? cfg_copy.fg_value : cfg_copy.bg_value;
			r.marked = hit;
			verdicts.push_back(r);
		end
		if (col + 1 >= w) begin
			col_pos = 0;
			if (row_pos < MAX_HEIGHT - 1) row_pos++;
		end else begin
			col_pos = col + 1;
		end
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endfunction

	// Driver: predicts on each transfer, then offers the next pixel when the slot is free.
	always @(posedge clk) begin : driver
		pixel_t next_px;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				classify_pixel(luma, frame_start);
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_px = pixel_queue.pop_front();
					in_valid    <= 1'b1;
					luma        <= next_px.luma;
					frame_start <= next_px.frame_start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin : receiver
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			out_stall   <= 1'b1;
			hold_left   <= LONG_HOLD;
			hold_served <= hold_served + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: each result transfer must match the oldest outstanding classification.
	always @(posedge clk) begin : monitor
		verdict_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{center_x, center_y, pixel_value, is_line};
			if (verdicts.size() == 0) begin
				note_failure($sformatf("unexpected result: x=%0d y=%0d value=%0d line=%0b",
					got.x, got.y, got.value, got.marked));
			end else begin
				want = verdicts.pop_front();
				if (got.x !== want.x || got.y !== want.y ||
					got.value !== want.value || got.marked !== want.marked)
					note_failure($sformatf(
						"mismatch: expected x=%0d y=%0d value=%0d line=%0b, got x=%0d y=%0d value=%0d line=%0b",
						want.x, want.y, want.value, want.marked,
						got.x, got.y, got.value, got.marked));
			end
		end
	end

	// Register writes are one per cycle; the predictor copy follows straight away,
	// which is safe because writes only happen while the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data[CFG_DATA_W-1:0];
		case (idx)
			REG_LUMA_TH:  cfg_copy.luma_th      = data[7:0];
			REG_DIFF_TH:  cfg_copy.diff_th      = data[7:0];
			REG_OFFSET:   cfg_copy.probe_offset = data[3:0];
			REG_WIDTH:    cfg_copy.image_width  = data[11:0];
			REG_FG_VALUE: cfg_copy.fg_value     = data[7:0];
			REG_BG_VALUE: cfg_copy.bg_value     = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int lt, input int dt, input int po, input int iw,
		input int fg, input int bg);
		write_reg(REG_LUMA_TH, lt);
		write_reg(REG_DIFF_TH, dt);
		write_reg(REG_OFFSET, po);
		write_reg(REG_WIDTH, iw);
		write_reg(REG_FG_VALUE, fg);
		write_reg(REG_BG_VALUE, bg);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every pushed pixel to transfer and every result to arrive, then pad.
	task automatic drain(input int pad);
		while (accepted_count != pushed_count || verdicts.size() != 0) @(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	function automatic void queue_pixel(input logic [LUMA_W-1:0] lv, input logic fs);
		pixel_queue.push_back('{lv, fs});
		pushed_count++;
		if (fs) begin
			gen_x = 0;
			gen_y = 0;
		end
		if (gen_x + 1 >= eff_width(cfg_copy.image_width)) begin
			gen_x = 0;
			gen_y++;
		end else begin
			gen_x++;
		end
	endfunction

	// Bright stripes or points on a dark ground, with a sprinkle of pure noise.
	function automatic logic [LUMA_W-1:0] shaped_luma();
		bit bright;
		bright = 1'b0;
		case (gen_style)
			STYLE_COLUMNS: bright = (gen_x % stripe_gap) == 0;
			STYLE_ROWS:    bright = (gen_y % stripe_gap) == 0;
			STYLE_POINTS:  bright = (gen_x % stripe_gap) == 0 && (gen_y % stripe_gap) == 0;
			default: ;
		endcase
		if (gen_style == STYLE_NOISE || $urandom_range(19) == 0) return 8'($urandom_range(255));
		return bright ? 8'($urandom_range(255, 140)) : 8'($urandom_range(90, 0));
	endfunction

	function automatic int pick_level();
		case ($urandom_range(3))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// One random frame under a fresh setting. Phase 1 pauses the sender half way
	// until every result is in; phase 2 has the receiver hold off for a long stretch.
	task automatic random_frame(input int phase, inout int item_total);
		int po, t, w, rows, n, lt, dt;
		po = ($urandom_range(9) < 7) ? $urandom_range(3, 1) : $urandom_range(15, 0);
		t  = eff_offset(po[3:0]);
		if (phase != 2 && $urandom_range(9) == 0)
			w = $urandom_range(2 * t, 1);          // too narrow, no results
		else
			w = 2 * t + 1 + $urandom_range(12);
		rows = 2 * t + 1 + $urandom_range(16);
		n    = w * rows + $urandom_range(w - 1);
		lt   = ($urandom_range(3) == 0) ? pick_level() : $urandom_range(160, 60);
		dt   = ($urandom_range(3) == 0) ? pick_level() : $urandom_range(90, 0);
		set_config(lt, dt, po, w, pick_level(), pick_level());
		gen_style  = pattern_t'($urandom_range(3));
		stripe_gap = $urandom_range(5, 2);
		if (phase == 2) hold_requests++;
		for (int i = 0; i < n; i++) begin
			if (phase == 1 && i == n / 2) drain(0);
			// occasional frame restart part way through a line
			queue_pixel(shaped_luma(), i == 0 || $urandom_range(199) == 0);
		end
		item_total += n;
		drain(DRAIN_PAD);
	endtask

	initial begin : stimulus
		logic [LUMA_W-1:0] ridge [15];
		logic [LUMA_W-1:0] cross_px [9];
		int random_total;
		int phase;
		ridge = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1, 8'd255, 8'd1,
			8'd0, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0};
		cross_px = '{8'd0, 8'd1, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1, 8'd0};
		random_total = 0;
		phase = 0;
		cfg_copy = '{LUMA_TH_RST, DIFF_TH_RST, OFFSET_RST, WIDTH_RST,
			FG_VALUE_RST, BG_VALUE_RST};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 17;
		recv_idle_pct = 57;

		// Directed: threshold met exactly, margin one above and exactly at the limit,
		// centre one below the threshold; offset 0 behaves as 1.
		set_config(255, 254, 0, 3, 255, 0);
		foreach (ridge[i]) queue_pixel(ridge[i], i == 0);
		drain(DRAIN_PAD);

		// Zero thresholds, inverted output levels, and a frame restart mid-line.
		set_config(0, 0, 1, 3, 0, 255);
		queue_pixel(8'd9, 1'b1);
		queue_pixel(8'd200, 1'b0);
		foreach (cross_px[i]) queue_pixel(cross_px[i], i == 0);
		drain(DRAIN_PAD);

		// Narrow images never classify: width 0 acts as 1, and width equal to 2t
		// with an over-range offset clamped to the maximum.
		set_config(80, 20, 1, 0, 255, 0);
		for (int i = 0; i < 12; i++) queue_pixel(8'($urandom_range(255)), i == 0);
		drain(DRAIN_PAD);
		set_config(0, 0, 15, 2 * MAX_OFFSET, 255, 0);
		for (int i = 0; i < 40; i++) queue_pixel(8'($urandom_range(255)), i == 0);
		drain(DRAIN_PAD);

		// Random frames through all three idling regimes; at least three frames so
		// that the sender pause and the long receiver hold-off both occur.
		while (random_total < RANDOM_ITEMS || phase < 3) begin
			if (random_total >= 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_total >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 17;
			end
			random_frame(phase, random_total);
			phase++;
		end

		if (fail_count == 0 && verdicts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
